>>> hw/rtl/dda2_pkg.sv
`timescale 1ns / 1ps

package dda2_pkg;

  localparam int SUBSTEPS   = 100000;
  localparam int TICK_BITS  = 14;
  localparam int TICK_W     = 14;
  localparam int INC_W      = 31;
  localparam int ACC_W      = 32;
  localparam int OPCODE_W   = 2;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int SUBSTEP_W  = $clog2(SUBSTEPS + 1);
  localparam int PROD_W     = TICK_BITS + SUBSTEP_W;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK    = 2'd0,
    OP_SEGMENT = 2'd1,
    OP_NULL    = 2'd2
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_ZERO = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_Z_POLARITY = 2'd0,
    REG_R_POLARITY = 2'd1
  } cfg_reg_t;

endpackage

>>> hw/rtl/dda_two_axis_step_generator.sv
`timescale 1ns / 1ps

// Two-axis DDA step generator with a one-deep segment buffer. Every input beat
// (a tick, a motion segment or a null segment) yields exactly one result beat,
// and a new beat is taken every clock cycle: the whole update, two accumulator
// adds with their sign tests, the countdown and a ticks-by-substeps constant
// multiply on segment load, sits between the state registers and one output
// register. Input is stalled only while that output register holds a result
// that the sink does not take in the same cycle. Polarity registers should be
// written only while no motion is in progress.
module dda_two_axis_step_generator (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dda2_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic                           cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [dda2_pkg::OPCODE_W-1:0]  opcode,
  input  logic [dda2_pkg::INC_W-1:0]     z_increment,
  input  logic [dda2_pkg::INC_W-1:0]     r_increment,
  input  logic                           z_direction,
  input  logic                           r_direction,
  input  logic [dda2_pkg::TICK_W-1:0]    tick_count,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           z_step,
  output logic                           r_step,
  output logic                           z_dir_pin,
  output logic                           r_dir_pin,
  output logic [dda2_pkg::STATUS_W-1:0]  status,
  output logic                           segment_loaded,
  output logic                           motion_complete
);
  import dda2_pkg::*;

  // Configuration
  logic z_polarity;
  logic r_polarity;

  // Segment buffer
  logic                 pending_valid;
  logic                 pending_null;
  logic                 pending_reset_mark;
  logic [INC_W-1:0]     pending_z_increment;
  logic [INC_W-1:0]     pending_r_increment;
  logic                 pending_z_dir;
  logic                 pending_r_dir;
  logic [TICK_BITS-1:0] pending_ticks;
  logic [TICK_BITS-1:0] previous_ticks;

  // Active segment
  logic [TICK_BITS-1:0] countdown;
  logic [INC_W-1:0]     ticks_times_substeps;
  logic [INC_W-1:0]     active_z_increment;
  logic [INC_W-1:0]     active_r_increment;
  logic [ACC_W-1:0]     z_accumulator;
  logic [ACC_W-1:0]     r_accumulator;
  logic                 z_dir_latch;
  logic                 r_dir_latch;

  // Next values
  logic                 pending_valid_next;
  logic                 pending_null_next;
  logic [TICK_BITS-1:0] countdown_next;
  logic [INC_W-1:0]     ticks_times_substeps_next;
  logic [INC_W-1:0]     active_z_increment_next;
  logic [INC_W-1:0]     active_r_increment_next;
  logic [ACC_W-1:0]     z_accumulator_next;
  logic [ACC_W-1:0]     r_accumulator_next;
  logic                 z_dir_latch_next;
  logic                 r_dir_latch_next;

  // Item decode
  logic                 in_fire;
  logic                 out_fire;
  opcode_t              op;
  logic [TICK_BITS-1:0] ticks_in;
  logic                 is_segment;
  status_t              status_now;
  logic                 accept_motion;
  logic                 accept_any;
  logic                 reset_mark_in;

  // Buffer contents as seen after this beat's segment is accepted
  logic                 eff_valid;
  logic                 eff_null;
  logic                 eff_reset_mark;
  logic [INC_W-1:0]     eff_z_increment;
  logic [INC_W-1:0]     eff_r_increment;
  logic                 eff_z_dir;
  logic                 eff_r_dir;
  logic [TICK_BITS-1:0] eff_ticks;

  logic                 tick_run;
  logic [TICK_BITS-1:0] countdown_dec;
  logic                 countdown_ends;
  logic                 load_now;
  logic                 motion_load;
  logic                 complete_now;
  logic [PROD_W-1:0]    ticks_product;

  logic [ACC_W-1:0]     z_sum;
  logic [ACC_W-1:0]     r_sum;
  logic [ACC_W-1:0]     z_sum_sub;
  logic [ACC_W-1:0]     r_sum_sub;
  logic                 z_fires;
  logic                 r_fires;
  logic [ACC_W-1:0]     z_acc_ticked;
  logic [ACC_W-1:0]     r_acc_ticked;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;

  always_comb begin
    op            = opcode_t'(opcode);
    ticks_in      = tick_count[TICK_BITS-1:0];
    is_segment    = (op == OP_SEGMENT) || (op == OP_NULL);
    reset_mark_in = ((TICK_BITS + 1)'({ticks_in, 1'b0})) <
                    ((TICK_BITS + 1)'(previous_ticks));

    status_now = ST_OK;
    if (is_segment) begin
      if (pending_valid) begin
        status_now = ST_FULL;
      end else if (op == OP_SEGMENT && ticks_in == '0) begin
        status_now = ST_ZERO;
      end
    end
    accept_any    = is_segment && (status_now == ST_OK);
    accept_motion = accept_any && (op == OP_SEGMENT);

    eff_valid       = pending_valid || accept_any;
    eff_null        = accept_any ? (op == OP_NULL) : pending_null;
    eff_reset_mark  = accept_motion ? reset_mark_in : pending_reset_mark;
    eff_z_increment = accept_motion ? z_increment : pending_z_increment;
    eff_r_increment = accept_motion ? r_increment : pending_r_increment;
    eff_z_dir       = accept_motion ? z_direction : pending_z_dir;
    eff_r_dir       = accept_motion ? r_direction : pending_r_dir;
    eff_ticks       = accept_motion ? ticks_in : pending_ticks;

    // DDA tick on both axes. The subtracted form is built alongside the plain
    // sum so that only a select follows the sign test.
    tick_run       = (op == OP_TICK) && (countdown != '0);
    countdown_dec  = countdown - 1'b1;
    countdown_ends = tick_run && (countdown_dec == '0);

    z_sum     = z_accumulator + ACC_W'(active_z_increment);
    r_sum     = r_accumulator + ACC_W'(active_r_increment);
    z_sum_sub = z_accumulator + ACC_W'(active_z_increment) - ACC_W'(ticks_times_substeps);
    r_sum_sub = r_accumulator + ACC_W'(active_r_increment) - ACC_W'(ticks_times_substeps);
    z_fires   = tick_run && (z_sum != '0) && !z_sum[ACC_W-1];
    r_fires   = tick_run && (r_sum != '0) && !r_sum[ACC_W-1];

    z_acc_ticked = z_accumulator;
    r_acc_ticked = r_accumulator;
    if (tick_run) begin
      z_acc_ticked = z_fires ? z_sum_sub : z_sum;
      r_acc_ticked = r_fires ? r_sum_sub : r_sum;
    end

    load_now = (countdown_ends && pending_valid) ||
               (accept_any && (countdown == '0) && eff_valid);
    motion_load  = load_now && !eff_null;
    complete_now = countdown_ends && !pending_valid;

    ticks_product = PROD_W'(eff_ticks) * PROD_W'(SUBSTEPS);

    pending_valid_next = load_now ? 1'b0 : eff_valid;
    pending_null_next  = load_now ? 1'b0 : eff_null;

    countdown_next            = tick_run ? countdown_dec : countdown;
    ticks_times_substeps_next = ticks_times_substeps;
    active_z_increment_next   = active_z_increment;
    active_r_increment_next   = active_r_increment;
    z_accumulator_next        = z_acc_ticked;
    r_accumulator_next        = r_acc_ticked;
    z_dir_latch_next          = z_dir_latch;
    r_dir_latch_next          = r_dir_latch;

    if (motion_load) begin
      countdown_next            = eff_ticks;
      ticks_times_substeps_next = INC_W'(ticks_product);
      active_z_increment_next   = eff_z_increment;
      active_r_increment_next   = eff_r_increment;
      if (eff_reset_mark) begin
        z_accumulator_next = ACC_W'(0) - ACC_W'(eff_ticks);
        r_accumulator_next = ACC_W'(0) - ACC_W'(eff_ticks);
      end
      // A direction is only taken up by an axis that actually moves.
      if (eff_z_increment != '0) begin
        z_dir_latch_next = eff_z_dir ^ z_polarity;
      end
      if (eff_r_increment != '0) begin
        r_dir_latch_next = eff_r_dir ^ r_polarity;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      z_polarity <= 1'b0;
      r_polarity <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_Z_POLARITY: z_polarity <= cfg_data;
        REG_R_POLARITY: r_polarity <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_valid        <= 1'b0;
      pending_null         <= 1'b0;
      pending_reset_mark   <= 1'b0;
      previous_ticks       <= '0;
      countdown            <= '0;
      ticks_times_substeps <= '0;
      active_z_increment   <= '0;
      active_r_increment   <= '0;
      z_accumulator        <= '0;
      r_accumulator        <= '0;
      z_dir_latch          <= 1'b0;
      r_dir_latch          <= 1'b0;
    end else if (in_fire) begin
      pending_valid        <= pending_valid_next;
      pending_null         <= pending_null_next;
      if (accept_motion) begin
        pending_reset_mark <= reset_mark_in;
        previous_ticks     <= ticks_in;
      end
      countdown            <= countdown_next;
      ticks_times_substeps <= ticks_times_substeps_next;
      active_z_increment   <= active_z_increment_next;
      active_r_increment   <= active_r_increment_next;
      z_accumulator        <= z_accumulator_next;
      r_accumulator        <= r_accumulator_next;
      z_dir_latch          <= z_dir_latch_next;
      r_dir_latch          <= r_dir_latch_next;
    end
  end

  // Buffer payload is only read while pending_valid is set.
  always_ff @(posedge clk) begin
    if (in_fire && accept_motion) begin
      pending_z_increment <= z_increment;
      pending_r_increment <= r_increment;
      pending_z_dir       <= z_direction;
      pending_r_dir       <= r_direction;
      pending_ticks       <= ticks_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      z_step          <= z_fires;
      r_step          <= r_fires;
      z_dir_pin       <= z_dir_latch_next;
      r_dir_pin       <= r_dir_latch_next;
      status          <= status_now;
      segment_loaded  <= motion_load;
      motion_complete <= complete_now;
    end
  end

  // The buffer never holds a segment while the block is idle.
  assert property (@(posedge clk) disable iff (rst)
    !(pending_valid && (countdown == '0)))
    else $error("segment left in buffer while idle");

  assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid)
    else $error("accepted beat produced no result");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(segment_loaded && motion_complete))
    else $error("load and motion complete in the same result");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != ST_OK)) |-> !segment_loaded)
    else $error("refused segment reported a load");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (z_step || r_step)) |-> (status == ST_OK) && !segment_loaded ||
      (status == ST_OK))
    else $error("step pulse on a refused segment");

endmodule

>>> sim/dda_step_checker.sv
`timescale 1ns / 1ps

module dda_step_checker
  import dda2_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [OPCODE_W-1:0]  opcode,
  input  logic [INC_W-1:0]     z_increment,
  input  logic [INC_W-1:0]     r_increment,
  input  logic                 z_direction,
  input  logic                 r_direction,
  input  logic [TICK_W-1:0]    tick_count,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic                 z_step,
  input  logic                 r_step,
  input  logic                 z_dir_pin,
  input  logic                 r_dir_pin,
  input  logic [STATUS_W-1:0]  status,
  input  logic                 segment_loaded,
  input  logic                 motion_complete,
  output int                   fail_count,
  output int                   expect_count,
  output logic                 motion_idle
);

  typedef struct packed {
    logic    z_step;
    logic    r_step;
    logic    z_dir_pin;
    logic    r_dir_pin;
    status_t status;
    logic    segment_loaded;
    logic    motion_complete;
  } step_result_t;

  step_result_t step_results_q[$];
  step_result_t observed;
  int           mismatches = 0;
  int           results_seen = 0;

  logic              z_pol, r_pol;
  logic              buf_valid, buf_null, buf_rewind;
  logic [INC_W-1:0]  buf_z_inc, buf_r_inc;
  logic              buf_z_dir, buf_r_dir;
  logic [TICK_W-1:0] buf_ticks, prev_ticks, countdown;
  logic [INC_W-1:0]  step_threshold, act_z_inc, act_r_inc;
  logic [ACC_W-1:0]  z_phase, r_phase;
  logic              z_dir_latch, r_dir_latch;

  assign fail_count = mismatches;

  // Adds the increment to one phase accumulator; a positive sum gives a step.
  function automatic logic axis_advance(input logic [ACC_W-1:0] acc,
                                        input logic [INC_W-1:0] inc,
                                        output logic [ACC_W-1:0] acc_out);
    logic [ACC_W-1:0] sum;
    sum = acc + {1'b0, inc};
    if (sum != '0 && !sum[ACC_W-1]) begin
      acc_out = sum - {1'b0, step_threshold};
      return 1'b1;
    end
    acc_out = sum;
    return 1'b0;
  endfunction

  // Empties the buffer and reports whether a motion segment went active.
  function automatic logic load_segment();
    logic        motion;
    logic [63:0] prod;
    motion = 1'b0;
    if (!buf_null) begin
      countdown = buf_ticks;
      prod = 64'(buf_ticks) * 64'(SUBSTEPS);
      step_threshold = prod[INC_W-1:0];
      act_z_inc = buf_z_inc;
      act_r_inc = buf_r_inc;
      if (buf_rewind) begin
        z_phase = 32'd0 - 32'(buf_ticks);
        r_phase = 32'd0 - 32'(buf_ticks);
      end
      if (act_z_inc != '0) z_dir_latch = buf_z_dir ^ z_pol;
      if (act_r_inc != '0) r_dir_latch = buf_r_dir ^ r_pol;
      motion = 1'b1;
    end
    buf_valid = 1'b0;
    buf_null = 1'b0;
    return motion;
  endfunction

  function automatic step_result_t predict_step(input logic [OPCODE_W-1:0] op,
                                                input logic [INC_W-1:0] zi,
                                                input logic [INC_W-1:0] ri,
                                                input logic zd,
                                                input logic rd,
                                                input logic [TICK_W-1:0] tc);
    step_result_t     res;
    logic [ACC_W-1:0] acc_next;
    res = '0;
    res.status = ST_OK;
    case (op)
      OP_TICK: begin
        if (countdown != '0) begin
          res.z_step = axis_advance(z_phase, act_z_inc, acc_next);
          z_phase = acc_next;
          res.r_step = axis_advance(r_phase, act_r_inc, acc_next);
          r_phase = acc_next;
          countdown = countdown - 1'b1;
          if (countdown == '0) begin
            if (buf_valid) res.segment_loaded = load_segment();
            else res.motion_complete = 1'b1;
          end
        end
      end
      OP_SEGMENT, OP_NULL: begin
        if (buf_valid) begin
          res.status = ST_FULL;
        end else if (op == OP_NULL) begin
          buf_valid = 1'b1;
          buf_null = 1'b1;
        end else if (tc == '0) begin
          res.status = ST_ZERO;
        end else begin
          buf_z_inc = zi;
          buf_r_inc = ri;
          buf_z_dir = zd;
          buf_r_dir = rd;
          buf_ticks = tc;
          // A much shorter segment restarts both accumulators on load.
          buf_rewind = (int'(tc) * 2) < int'(prev_ticks);
          prev_ticks = tc;
          buf_valid = 1'b1;
          buf_null = 1'b0;
        end
        if (res.status == ST_OK && countdown == '0 && buf_valid)
          res.segment_loaded = load_segment();
      end
      default: begin
      end
    endcase
    res.z_dir_pin = z_dir_latch;
    res.r_dir_pin = r_dir_latch;
    return res;
  endfunction

  task automatic report_failure(input string msg);
    $display("%t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [1:0] got,
                             input logic [1:0] want);
    if (got !== want)
      report_failure($sformatf("result beat %0d: %s is %0h, expected %0h",
                               results_seen, name, got, want));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      z_pol = 1'b0;
      r_pol = 1'b0;
      buf_valid = 1'b0;
      buf_null = 1'b0;
      buf_rewind = 1'b0;
      buf_z_inc = '0;
      buf_r_inc = '0;
      buf_z_dir = 1'b0;
      buf_r_dir = 1'b0;
      buf_ticks = '0;
      prev_ticks = '0;
      countdown = '0;
      step_threshold = '0;
      act_z_inc = '0;
      act_r_inc = '0;
      z_phase = '0;
      r_phase = '0;
      z_dir_latch = 1'b0;
      r_dir_latch = 1'b0;
      step_results_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_Z_POLARITY: z_pol = cfg_data;
          REG_R_POLARITY: r_pol = cfg_data;
          default: begin
          end
        endcase
      end
      if (in_valid && in_ready)
        step_results_q.push_back(predict_step(opcode, z_increment, r_increment,
                                              z_direction, r_direction, tick_count));
      if (out_valid && out_ready) begin
        observed.z_step = z_step;
        observed.r_step = r_step;
        observed.z_dir_pin = z_dir_pin;
        observed.r_dir_pin = r_dir_pin;
        observed.status = status_t'(status);
        observed.segment_loaded = segment_loaded;
        observed.motion_complete = motion_complete;
        if (step_results_q.size() == 0) begin
          report_failure($sformatf("result beat %0d arrived with nothing expected",
                                   results_seen));
        end else begin
          check_field("z_step", 2'(observed.z_step), 2'(step_results_q[0].z_step));
          check_field("r_step", 2'(observed.r_step), 2'(step_results_q[0].r_step));
          check_field("z_dir_pin", 2'(observed.z_dir_pin),
                      2'(step_results_q[0].z_dir_pin));
          check_field("r_dir_pin", 2'(observed.r_dir_pin),
                      2'(step_results_q[0].r_dir_pin));
          check_field("status", observed.status, step_results_q[0].status);
          check_field("segment_loaded", 2'(observed.segment_loaded),
                      2'(step_results_q[0].segment_loaded));
          check_field("motion_complete", 2'(observed.motion_complete),
                      2'(step_results_q[0].motion_complete));
          void'(step_results_q.pop_front());
        end
        results_seen++;
      end
    end
    expect_count <= step_results_q.size();
    motion_idle <= (countdown == '0) && !buf_valid;
  end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import dda2_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int TICK_MAX = 2**TICK_BITS - 1;
  localparam logic [INC_W-1:0] INC_MAX = INC_W'(TICK_MAX * SUBSTEPS);
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 200;
  localparam int SETTLE_CYCLES = 20;
  localparam int PHASE_ITEMS = 160;
  localparam int LONG_TICKS = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic                 cfg_data = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [OPCODE_W-1:0] opcode = '0;
  logic [INC_W-1:0]    z_increment = '0;
  logic [INC_W-1:0]    r_increment = '0;
  logic                z_direction = 1'b0;
  logic                r_direction = 1'b0;
  logic [TICK_W-1:0]   tick_count = '0;

  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                z_step, r_step, z_dir_pin, r_dir_pin;
  logic [STATUS_W-1:0] status;
  logic                segment_loaded, motion_complete;

  int   fail_count;
  int   expect_count;
  logic motion_idle;

  int   items_sent = 0;
  logic src_gaps = 1'b1;
  logic sink_gaps = 1'b1;
  int   hold_requests = 0;
  int   holds_served = 0;
  int   hold_left = 0;
  int   quiet_cycles = 0;

  always #1 clk = ~clk;

  dda_two_axis_step_generator u_dut (.*);

  dda_step_checker u_checker (.*);

  // The receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      out_ready <= 1'b0;
      holds_served <= holds_served + 1;
      hold_left <= HOLD_CYCLES;
    end else if (sink_gaps) begin
      out_ready <= ($urandom_range(99) >= 20);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("FAIL dda_two_axis_step_generator");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int pick_ticks();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 0;
    if (r < 85) return $urandom_range(12, 1);
    return $urandom_range(300, 13);
  endfunction

  // Mostly rates that step at most once per tick, sometimes anything legal.
  function automatic logic [INC_W-1:0] pick_increment(input int ticks);
    case ($urandom_range(9))
      0: return '0;
      1: return INC_MAX;
      2: return INC_W'($urandom_range(INC_MAX, 0));
      default: return INC_W'($urandom_range(ticks * SUBSTEPS, 0));
    endcase
  endfunction

  task automatic send_item(input logic [OPCODE_W-1:0] op,
                           input logic [INC_W-1:0] zi, input logic [INC_W-1:0] ri,
                           input logic zd, input logic rd,
                           input logic [TICK_W-1:0] tc);
    while (src_gaps && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    z_increment <= zi;
    r_increment <= ri;
    z_direction <= zd;
    r_direction <= rd;
    tick_count <= tc;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_tick();
    send_item(OP_TICK, INC_W'($urandom_range(INC_MAX, 0)),
              INC_W'($urandom_range(INC_MAX, 0)), 1'($urandom_range(1)),
              1'($urandom_range(1)), TICK_W'($urandom_range(TICK_MAX, 0)));
  endtask

  task automatic send_segment(input int ticks);
    send_item(OP_SEGMENT, pick_increment(ticks), pick_increment(ticks),
              1'($urandom_range(1)), 1'($urandom_range(1)), TICK_W'(ticks));
  endtask

  task automatic send_null();
    send_item(OP_NULL, INC_W'($urandom_range(INC_MAX, 0)),
              INC_W'($urandom_range(INC_MAX, 0)), 1'($urandom_range(1)),
              1'($urandom_range(1)), TICK_W'($urandom_range(TICK_MAX, 0)));
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expect_count != 0);
  endtask

  // Ticks the block until no segment is running or buffered.
  task automatic settle_motion();
    wait_results();
    while (!motion_idle) send_tick();
    wait_results();
  endtask

  task automatic write_polarity(input logic zp, input logic rp);
    cfg_valid <= 1'b1;
    cfg_index <= REG_Z_POLARITY;
    cfg_data <= zp;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_R_POLARITY;
    cfg_data <= rp;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // A segment followed by roughly its own length of ticks, with new segments
  // and null segments dropped in while it runs; otherwise one random beat.
  task automatic run_burst();
    int r, ticks, n;
    r = $urandom_range(99);
    if (r < 75) begin
      ticks = pick_ticks();
      send_segment(ticks);
      n = $urandom_range(ticks + 4, ticks / 2);
      repeat (n) begin
        r = $urandom_range(99);
        if (r < 6) send_segment(pick_ticks());
        else if (r < 9) send_null();
        else send_tick();
      end
    end else begin
      send_item(OPCODE_W'($urandom_range(3)), INC_W'($urandom_range(INC_MAX, 0)),
                INC_W'($urandom_range(INC_MAX, 0)), 1'($urandom_range(1)),
                1'($urandom_range(1)), TICK_W'($urandom_range(TICK_MAX, 0)));
    end
  endtask

  task automatic run_items(input int count);
    int target;
    target = items_sent + count;
    while (items_sent < target) run_burst();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_item(OP_TICK, '0, '0, 1'b0, 1'b0, '0);
    send_item(OP_UNUSED, INC_MAX, INC_MAX, 1'b1, 1'b1, TICK_W'(TICK_MAX));
    send_item(OP_SEGMENT, INC_MAX, INC_MAX, 1'b1, 1'b1, '0);
    // Zero first-axis increment: its direction latch must hold.
    send_item(OP_SEGMENT, '0, INC_W'(2 * SUBSTEPS), 1'b1, 1'b1, TICK_W'(3));
    send_item(OP_SEGMENT, INC_W'(SUBSTEPS), INC_W'(SUBSTEPS), 1'b0, 1'b1, TICK_W'(1));
    send_item(OP_NULL, '0, '0, 1'b0, 1'b0, '0);
    send_item(OP_SEGMENT, INC_W'(SUBSTEPS), INC_W'(SUBSTEPS), 1'b1, 1'b0, TICK_W'(5));
    repeat (3) send_tick();
    send_item(OP_NULL, '0, '0, 1'b0, 1'b0, '0);
    repeat (2) send_tick();
    send_item(OP_NULL, '0, '0, 1'b0, 1'b0, '0);
    // Largest increments against a short segment wrap the accumulators.
    send_item(OP_SEGMENT, INC_MAX, INC_MAX, 1'b0, 1'b0, TICK_W'(2));
    repeat (3) send_tick();
    send_item(OP_SEGMENT, '0, '0, 1'b1, 1'b1, TICK_W'(1));
    send_tick();

    // A long segment, then a one-tick segment that rewinds the accumulators.
    settle_motion();
    send_segment(LONG_TICKS);
    send_item(OP_SEGMENT, INC_MAX, '0, 1'b1, 1'b0, TICK_W'(1));
    settle_motion();

    for (int p = 0; p < 4; p++) begin
      settle_motion();
      write_polarity(p[0], p[1]);
      src_gaps = (p != 1);
      sink_gaps <= (p != 1);
      run_items(PHASE_ITEMS / 3);
      if (p == 2) begin
        hold_requests <= hold_requests + 1;
        run_items(60);
        wait_results();
      end
      run_items(PHASE_ITEMS - PHASE_ITEMS / 3);
    end

    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS dda_two_axis_step_generator");
    end else begin
      $display("FAIL dda_two_axis_step_generator");
    end
    $finish;
  end

endmodule
